### rtl/core/cmt_pkg.sv
package cmt_pkg;

  // Fixed register layout: four 16-bit two's complement lanes per 64-bit row
  localparam int unsigned LANE_BITS = 16;
  localparam int unsigned NUM_CHANS = 4;
  localparam int unsigned NUM_ROWS = 5;
  localparam int unsigned REG_BITS = NUM_CHANS * LANE_BITS;
  localparam int unsigned CFG_IDX_BITS = 3;

  // Pipeline depth: product, sum, round/saturate
  localparam int unsigned NUM_STAGES = 3;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RED_ROW    = 3'd0,
    CFG_GREEN_ROW  = 3'd1,
    CFG_BLUE_ROW   = 3'd2,
    CFG_ALPHA_ROW  = 3'd3,
    CFG_OFFSET_ROW = 3'd4
  } cfg_index_e;

  // Stage load enables from the pipeline control to the datapath lanes
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } stage_ctl_t;

endpackage

### rtl/core/cmt_pipe_ctrl.sv
module cmt_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cmt_pkg::stage_ctl_t ctl_o
);

  localparam int unsigned NS = cmt_pkg::NUM_STAGES;

  logic [NS-1:0] valid_q;
  logic [NS-1:0] valid_d;
  logic [NS:0]   stage_ready;
  logic [NS-1:0] stage_valid;

  // A stage may load when it is empty or its item moves on this cycle
  always_comb begin
    stage_ready[NS] = out_ready_i;
    stage_valid[0]  = in_valid_i;
    for (int s = NS - 1; s >= 0; s--) begin
      stage_ready[s] = !valid_q[s] || stage_ready[s+1];
    end
    for (int s = 0; s < NS - 1; s++) begin
      stage_valid[s+1] = valid_q[s];
    end
    for (int s = 0; s < NS; s++) begin
      ctl_o.load[s] = stage_ready[s];
      valid_d[s]    = stage_ready[s] ? stage_valid[s] : valid_q[s];
    end
  end

  // Advance the valid bits along with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = stage_ready[0];
  assign out_valid_o = valid_q[NS-1];

`ifndef SYNTHESIS
  // Input backpressure only when every stage holds an item
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> &valid_q)
    else $error("input stalled with an empty stage");

  // An accepted item occupies the first stage next cycle
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted item lost at the first stage");

  // A middle item that cannot move is kept
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] && !ctl_o.load[2] |=> valid_q[1])
    else $error("stalled item dropped in the sum stage");
`endif

endmodule

### rtl/core/cmt_lane.sv
module cmt_lane #(
  parameter int unsigned CHANNEL_BITS   = 8,
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic                                                      clk_i,
  input  cmt_pkg::stage_ctl_t                                       ctl_i,
  input  logic [cmt_pkg::NUM_CHANS-1:0][CHANNEL_BITS-1:0]           pixel_i,
  input  logic [cmt_pkg::NUM_ROWS-1:0][cmt_pkg::LANE_BITS-1:0]      coef_i,
  output logic [CHANNEL_BITS-1:0]                                   chan_o,
  output logic                                                      clamp_o
);

  localparam int unsigned PROD_W = CHANNEL_BITS + cmt_pkg::LANE_BITS + 1;
  localparam int unsigned ACC_W  = PROD_W + 3;
  localparam int unsigned NR     = cmt_pkg::NUM_ROWS;
  localparam int unsigned NC     = cmt_pkg::NUM_CHANS;

  logic signed [PROD_W-1:0] prod_d [NR];
  logic signed [PROD_W-1:0] prod_q [NR];
  logic signed [ACC_W-1:0]  sum_d;
  logic signed [ACC_W-1:0]  sum_q;
  logic signed [ACC_W-1:0]  biased;
  logic signed [ACC_W-1:0]  scaled;
  logic signed [ACC_W-1:0]  full_ext;
  logic [CHANNEL_BITS-1:0]  chan_d;
  logic [CHANNEL_BITS-1:0]  chan_q;
  logic                     clamp_d;
  logic                     clamp_q;
  logic signed [CHANNEL_BITS:0] full_px;

  // Products: each channel times its coefficient, offset times full scale
  assign full_px = $signed({1'b0, {CHANNEL_BITS{1'b1}}});

  always_comb begin
    for (int j = 0; j < NC; j++) begin
      prod_d[j] = $signed({1'b0, pixel_i[j]}) * $signed(coef_i[j]);
    end
    prod_d[NR-1] = full_px * $signed(coef_i[NR-1]);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[0]) begin
      prod_q <= prod_d;
    end
  end

  // Accumulate the five products
  always_comb begin
    sum_d = '0;
    for (int j = 0; j < NR; j++) begin
      sum_d = sum_d + ACC_W'(prod_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[1]) begin
      sum_q <= sum_d;
    end
  end

  // Round half up, drop the fraction, saturate to 0..full scale
  always_comb begin
    full_ext = $signed(ACC_W'({CHANNEL_BITS{1'b1}}));
    biased   = sum_q + $signed(ACC_W'(1) << (COEF_FRAC_BITS - 1));
    scaled   = biased >>> COEF_FRAC_BITS;
    if (biased[ACC_W-1]) begin
      chan_d  = '0;
      clamp_d = 1'b1;
    end else if (scaled > full_ext) begin
      chan_d  = {CHANNEL_BITS{1'b1}};
      clamp_d = 1'b1;
    end else begin
      chan_d  = scaled[CHANNEL_BITS-1:0];
      clamp_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[2]) begin
      chan_q  <= chan_d;
      clamp_q <= clamp_d;
    end
  end

  assign chan_o  = chan_q;
  assign clamp_o = clamp_q;

endmodule

### rtl/core/colour_matrix_transform_top.sv
// RGBA 5x5 affine colour matrix. Each pixel's four channels are multiplied by
// a 4x4 matrix of signed Q3.12 coefficients (COEF_FRAC_BITS fraction bits),
// an offset row scaled by full scale is added, and each output is rounded
// half up and saturated to 0..full scale; clamped flags any saturation. Rows
// are written through the configuration port (index 0..3 red, green, blue,
// alpha input; 4 offset; higher indexes ignored), lane k of a row feeding
// output k; reset loads the identity. Write rows only while no pixel is in
// flight. The datapath is a three-stage pipeline (products, sum,
// round/saturate), each stage ending in a register, and one pixel is taken
// every cycle unless the output stalls with all three stages full.
module colour_matrix_transform_top #(
  parameter int unsigned CHANNEL_BITS   = 8,
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cmt_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [cmt_pkg::REG_BITS-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [CHANNEL_BITS-1:0]             red_in_i,
  input  logic [CHANNEL_BITS-1:0]             green_in_i,
  input  logic [CHANNEL_BITS-1:0]             blue_in_i,
  input  logic [CHANNEL_BITS-1:0]             alpha_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [CHANNEL_BITS-1:0]             red_out_o,
  output logic [CHANNEL_BITS-1:0]             green_out_o,
  output logic [CHANNEL_BITS-1:0]             blue_out_o,
  output logic [CHANNEL_BITS-1:0]             alpha_out_o,
  output logic                                clamped_o
);

  localparam int unsigned LB = cmt_pkg::LANE_BITS;
  localparam int unsigned NR = cmt_pkg::NUM_ROWS;
  localparam int unsigned NC = cmt_pkg::NUM_CHANS;
  localparam logic [LB-1:0] COEF_ONE = LB'(1) << COEF_FRAC_BITS;

  logic [NR-1:0][cmt_pkg::REG_BITS-1:0]       row_q;
  logic [NC-1:0][CHANNEL_BITS-1:0]            pixel;
  logic [NC-1:0][CHANNEL_BITS-1:0]            chan_out;
  logic [NC-1:0]                              lane_clamp;
  cmt_pkg::stage_ctl_t                        ctl;

  // Coefficient rows; reset to the identity transform
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NC; j++) begin
        row_q[j] <= cmt_pkg::REG_BITS'(COEF_ONE) << (LB * j);
      end
      row_q[NR-1] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cmt_pkg::CFG_RED_ROW:    row_q[0] <= cfg_data_i;
        cmt_pkg::CFG_GREEN_ROW:  row_q[1] <= cfg_data_i;
        cmt_pkg::CFG_BLUE_ROW:   row_q[2] <= cfg_data_i;
        cmt_pkg::CFG_ALPHA_ROW:  row_q[3] <= cfg_data_i;
        cmt_pkg::CFG_OFFSET_ROW: row_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake and stage enables
  cmt_pipe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ctl_o      (ctl)
  );

  assign pixel[0] = red_in_i;
  assign pixel[1] = green_in_i;
  assign pixel[2] = blue_in_i;
  assign pixel[3] = alpha_in_i;

  // One datapath lane per output channel, fed by lane k of every row
  for (genvar k = 0; k < NC; k++) begin : g_lane
    logic [NR-1:0][LB-1:0] coef;

    for (genvar j = 0; j < NR; j++) begin : g_coef
      assign coef[j] = row_q[j][LB*k +: LB];
    end

    cmt_lane #(
      .CHANNEL_BITS  (CHANNEL_BITS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .pixel_i(pixel),
      .coef_i (coef),
      .chan_o (chan_out[k]),
      .clamp_o(lane_clamp[k])
    );
  end

  assign red_out_o   = chan_out[0];
  assign green_out_o = chan_out[1];
  assign blue_out_o  = chan_out[2];
  assign alpha_out_o = chan_out[3];
  assign clamped_o   = |lane_clamp;

endmodule
